[hw/rtl/indexed_min_heap_queue_macros.svh]
// assertion macros for the indexed min-heap queue
`ifndef INDEXED_MIN_HEAP_QUEUE_MACROS_SVH
`define INDEXED_MIN_HEAP_QUEUE_MACROS_SVH

// same-cycle implication, checked out of reset
`define IMHQ_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("heap queue check failed");

// next-cycle implication, checked out of reset
`define IMHQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("heap queue check failed");

`endif

[hw/rtl/imhq_pkg.sv]
// shared types, codes and helpers for the indexed min-heap queue
package imhq_pkg;

    localparam int HEAP_CAPACITY = 256;
    localparam int ADDR_W        = $clog2(HEAP_CAPACITY);
    localparam int SLOT_W        = 9;
    localparam int CHD_W         = SLOT_W + 1;

    // operation codes
    localparam logic [2:0] FN_INSERT  = 3'd0;
    localparam logic [2:0] FN_EXTRACT = 3'd1;
    localparam logic [2:0] FN_POP     = 3'd2;
    localparam logic [2:0] FN_UPDATE  = 3'd3;
    localparam logic [2:0] FN_PEEK    = 3'd4;
    localparam logic [2:0] FN_FIND    = 3'd5;
    localparam logic [2:0] FN_READ    = 3'd6;
    localparam logic [2:0] FN_CLEAR   = 3'd7;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_EMPTY    = 3'd1;
    localparam logic [2:0] ST_FULL     = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_BADSLOT  = 3'd4;

    typedef struct packed {
        logic [31:0] id;
        logic [31:0] key;
        logic [31:0] mp;
        logic [31:0] lp;
        logic [31:0] pay;
    } entry_t;

    typedef enum logic [2:0] {
        RD_NONE, RD_ROOT, RD_SLOT, RD_LAST, RD_PARENT, RD_CHD, RD_CHD1, RD_POS
    } rd_sel_t;

    typedef enum logic [4:0] {
        A_NONE, A_LOAD, A_FAIL, A_CLEAR, A_INS_START, A_UP_MOVE, A_UP_PLACE,
        A_ROOT_RES, A_EXT_LAST, A_POP_START, A_UPD_START, A_DN_C1, A_DN_C2,
        A_DN_MOVE, A_DN_PLACE, A_PEEK_RES, A_READ_RES, A_SCAN_START, A_SCAN_STEP
    } act_t;

    typedef struct packed {
        rd_sel_t    rd;
        act_t       act;
        logic [2:0] st;
        logic       out_load;
    } cmd_t;

    typedef struct packed {
        logic [2:0] func;
        logic       occ_zero;
        logic       occ_full;
        logic       slot_bad;
        logic       pos_gt1;
        logic       up_less;
        logic       chd_gt_occ;
        logic       chd_lt_occ;
        logic       cand_less;
        logic       id_match;
        logic       scan_end;
    } flags_t;

    // signed Q16.16 key compare
    function automatic logic key_less(input logic [31:0] a, input logic [31:0] b);
        return $signed(a) < $signed(b);
    endfunction

endpackage

[hw/rtl/imhq_datapath.sv]
// heap storage, sift registers and result registers
module imhq_datapath (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  imhq_pkg::cmd_t       cmd,
    output imhq_pkg::flags_t     flags,
    input  logic [2:0]           in_func,
    input  imhq_pkg::entry_t     in_ent,
    input  logic [8:0]           in_slot,
    output logic [2:0]           out_status,
    output logic [8:0]           out_slot,
    output imhq_pkg::entry_t     out_ent,
    output logic [8:0]           out_count
);

    typedef logic [imhq_pkg::ADDR_W-1:0] addr_t;

    imhq_pkg::entry_t mem [imhq_pkg::HEAP_CAPACITY];
    imhq_pkg::entry_t mem_q_reg;

    logic [2:0]                    func_reg;
    imhq_pkg::entry_t              ne_reg;
    logic [imhq_pkg::SLOT_W-1:0]   slot_reg;
    logic [imhq_pkg::SLOT_W-1:0]   occ_reg, occ_next;
    logic [imhq_pkg::SLOT_W-1:0]   pos_reg, pos_next;
    logic [imhq_pkg::CHD_W-1:0]    chd_reg, chd_next;
    imhq_pkg::entry_t              ent_reg, ent_next;
    imhq_pkg::entry_t              cand_reg, cand_next;
    imhq_pkg::entry_t              res_reg, res_next;
    logic [2:0]                    rst_reg, rst_next;
    logic [imhq_pkg::SLOT_W-1:0]   rslot_reg, rslot_next;

    logic [2:0]                    ost_reg;
    logic [imhq_pkg::SLOT_W-1:0]   oslot_reg;
    imhq_pkg::entry_t              oent_reg;
    logic [imhq_pkg::SLOT_W-1:0]   ocnt_reg;

    logic [imhq_pkg::SLOT_W-1:0]   rd_slot;
    logic [imhq_pkg::SLOT_W-1:0]   wr_slot;
    logic [imhq_pkg::CHD_W-1:0]    chd_inc;
    logic                          wr_en;
    imhq_pkg::entry_t              wr_data;

    assign chd_inc = chd_reg + imhq_pkg::CHD_W'(1);

    // read address select
    always_comb begin
        unique case (cmd.rd)
            imhq_pkg::RD_ROOT:   rd_slot = imhq_pkg::SLOT_W'(1);
            imhq_pkg::RD_SLOT:   rd_slot = slot_reg;
            imhq_pkg::RD_LAST:   rd_slot = occ_reg;
            imhq_pkg::RD_PARENT: rd_slot = pos_reg >> 1;
            imhq_pkg::RD_CHD:    rd_slot = chd_reg[imhq_pkg::SLOT_W-1:0];
            imhq_pkg::RD_CHD1:   rd_slot = chd_inc[imhq_pkg::SLOT_W-1:0];
            imhq_pkg::RD_POS:    rd_slot = pos_reg;
            default:             rd_slot = '0;
        endcase
    end

    // status back to the controller
    always_comb begin
        flags.func       = func_reg;
        flags.occ_zero   = (occ_reg == '0);
        flags.occ_full   = (occ_reg >= imhq_pkg::SLOT_W'(imhq_pkg::HEAP_CAPACITY));
        flags.slot_bad   = (slot_reg == '0) || (slot_reg > occ_reg);
        flags.pos_gt1    = (pos_reg > imhq_pkg::SLOT_W'(1));
        flags.up_less    = imhq_pkg::key_less(ent_reg.key, mem_q_reg.key);
        flags.chd_gt_occ = (chd_reg > {1'b0, occ_reg});
        flags.chd_lt_occ = (chd_reg < {1'b0, occ_reg});
        flags.cand_less  = imhq_pkg::key_less(cand_reg.key, ent_reg.key);
        flags.id_match   = (mem_q_reg.id == ne_reg.id);
        flags.scan_end   = (pos_reg > occ_reg);
    end

    // micro-operation next state
    always_comb begin
        occ_next   = occ_reg;
        pos_next   = pos_reg;
        chd_next   = chd_reg;
        ent_next   = ent_reg;
        cand_next  = cand_reg;
        res_next   = res_reg;
        rst_next   = rst_reg;
        rslot_next = rslot_reg;
        wr_en      = 1'b0;
        wr_slot    = pos_reg;
        wr_data    = ent_reg;
        unique case (cmd.act)
            imhq_pkg::A_FAIL: begin
                rst_next   = cmd.st;
                rslot_next = '0;
                res_next   = '0;
            end
            imhq_pkg::A_CLEAR: begin
                occ_next   = '0;
                rst_next   = imhq_pkg::ST_OK;
                rslot_next = '0;
                res_next   = '0;
            end
            imhq_pkg::A_INS_START: begin
                occ_next = occ_reg + imhq_pkg::SLOT_W'(1);
                pos_next = occ_reg + imhq_pkg::SLOT_W'(1);
                ent_next = ne_reg;
            end
            imhq_pkg::A_UP_MOVE: begin
                wr_en    = 1'b1;
                wr_data  = mem_q_reg;
                pos_next = pos_reg >> 1;
            end
            imhq_pkg::A_UP_PLACE: begin
                wr_en      = 1'b1;
                res_next   = ent_reg;
                rst_next   = imhq_pkg::ST_OK;
                rslot_next = pos_reg;
            end
            imhq_pkg::A_ROOT_RES: begin
                res_next = mem_q_reg;
            end
            imhq_pkg::A_EXT_LAST: begin
                ent_next = mem_q_reg;
                occ_next = occ_reg - imhq_pkg::SLOT_W'(1);
                pos_next = imhq_pkg::SLOT_W'(1);
                chd_next = imhq_pkg::CHD_W'(2);
            end
            imhq_pkg::A_POP_START: begin
                ent_next = ne_reg;
                pos_next = imhq_pkg::SLOT_W'(1);
                chd_next = imhq_pkg::CHD_W'(2);
            end
            imhq_pkg::A_UPD_START: begin
                ent_next     = mem_q_reg;
                ent_next.key = ne_reg.key;
                ent_next.mp  = ne_reg.mp;
                pos_next     = slot_reg;
                chd_next     = {slot_reg, 1'b0};
            end
            imhq_pkg::A_DN_C1: begin
                cand_next = mem_q_reg;
            end
            imhq_pkg::A_DN_C2: begin
                if (imhq_pkg::key_less(mem_q_reg.key, cand_reg.key)) begin
                    cand_next = mem_q_reg;
                    chd_next  = chd_inc;
                end
            end
            imhq_pkg::A_DN_MOVE: begin
                wr_en    = 1'b1;
                wr_data  = cand_reg;
                pos_next = chd_reg[imhq_pkg::SLOT_W-1:0];
                chd_next = {chd_reg[imhq_pkg::SLOT_W-1:0], 1'b0};
            end
            imhq_pkg::A_DN_PLACE: begin
                wr_en    = 1'b1;
                rst_next = imhq_pkg::ST_OK;
                case (func_reg)
                    imhq_pkg::FN_EXTRACT: rslot_next = '0;
                    imhq_pkg::FN_UPDATE: begin
                        rslot_next = pos_reg;
                        res_next   = ent_reg;
                    end
                    default: rslot_next = pos_reg;
                endcase
            end
            imhq_pkg::A_PEEK_RES: begin
                res_next   = mem_q_reg;
                rst_next   = imhq_pkg::ST_OK;
                rslot_next = imhq_pkg::SLOT_W'(1);
            end
            imhq_pkg::A_READ_RES: begin
                res_next   = mem_q_reg;
                rst_next   = imhq_pkg::ST_OK;
                rslot_next = slot_reg;
            end
            imhq_pkg::A_SCAN_START: begin
                pos_next = imhq_pkg::SLOT_W'(1);
            end
            imhq_pkg::A_SCAN_STEP: begin
                if (mem_q_reg.id == ne_reg.id) begin
                    res_next   = mem_q_reg;
                    rst_next   = imhq_pkg::ST_OK;
                    rslot_next = pos_reg;
                end else begin
                    pos_next = pos_reg + imhq_pkg::SLOT_W'(1);
                end
            end
            default: ;
        endcase
    end

    // heap memory, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[addr_t'(wr_slot - imhq_pkg::SLOT_W'(1))] <= wr_data;
        end
        if (cmd.rd != imhq_pkg::RD_NONE) begin
            mem_q_reg <= mem[addr_t'(rd_slot - imhq_pkg::SLOT_W'(1))];
        end
    end

    // occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg <= '0;
        end else begin
            occ_reg <= occ_next;
        end
    end

    // working and output word registers
    always_ff @(posedge aclk) begin
        pos_reg   <= pos_next;
        chd_reg   <= chd_next;
        ent_reg   <= ent_next;
        cand_reg  <= cand_next;
        res_reg   <= res_next;
        rst_reg   <= rst_next;
        rslot_reg <= rslot_next;
        if (cmd.act == imhq_pkg::A_LOAD) begin
            func_reg <= in_func;
            ne_reg   <= in_ent;
            slot_reg <= in_slot;
        end
        if (cmd.out_load) begin
            ost_reg   <= rst_reg;
            oslot_reg <= rslot_reg;
            oent_reg  <= res_reg;
            ocnt_reg  <= occ_reg;
        end
    end

    assign out_status = ost_reg;
    assign out_slot   = oslot_reg;
    assign out_ent    = oent_reg;
    assign out_count  = ocnt_reg;

endmodule

[hw/rtl/imhq_ctrl.sv]
// operation sequencer and handshake control for the heap queue
module imhq_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    output logic               m_valid,
    input  logic               m_ready,
    input  imhq_pkg::flags_t   flags,
    output imhq_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_DISPATCH, S_EXT_R, S_EXT_L, S_POP_R, S_POP_S, S_UPD_R,
        S_PEEK_R, S_READ_R, S_UP_CHK, S_UP_CMP, S_DN_CHK, S_DN_C1, S_DN_C2,
        S_DN_DEC, S_SCAN_CHK, S_SCAN_CMP, S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   mvalid_reg, mvalid_next;
    logic   out_free;

    assign out_free = !mvalid_reg || m_ready;
    assign s_ready  = (state_reg == S_IDLE);
    assign m_valid  = mvalid_reg;

    // next state and command decode
    always_comb begin
        state_next   = state_reg;
        mvalid_next  = mvalid_reg && !m_ready;
        cmd.rd       = imhq_pkg::RD_NONE;
        cmd.act      = imhq_pkg::A_NONE;
        cmd.st       = imhq_pkg::ST_OK;
        cmd.out_load = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    cmd.act    = imhq_pkg::A_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                state_next = S_DONE;
                unique case (flags.func) inside
                    imhq_pkg::FN_INSERT: begin
                        if (flags.occ_full) begin
                            cmd.act = imhq_pkg::A_FAIL;
                            cmd.st  = imhq_pkg::ST_FULL;
                        end else begin
                            cmd.act    = imhq_pkg::A_INS_START;
                            state_next = S_UP_CHK;
                        end
                    end
                    imhq_pkg::FN_EXTRACT, imhq_pkg::FN_POP, imhq_pkg::FN_PEEK: begin
                        if (flags.occ_zero) begin
                            cmd.act = imhq_pkg::A_FAIL;
                            cmd.st  = imhq_pkg::ST_EMPTY;
                        end else begin
                            cmd.rd = imhq_pkg::RD_ROOT;
                            if (flags.func == imhq_pkg::FN_EXTRACT) begin
                                state_next = S_EXT_R;
                            end else if (flags.func == imhq_pkg::FN_POP) begin
                                state_next = S_POP_R;
                            end else begin
                                state_next = S_PEEK_R;
                            end
                        end
                    end
                    imhq_pkg::FN_UPDATE, imhq_pkg::FN_READ: begin
                        if (flags.slot_bad) begin
                            cmd.act = imhq_pkg::A_FAIL;
                            cmd.st  = imhq_pkg::ST_BADSLOT;
                        end else begin
                            cmd.rd     = imhq_pkg::RD_SLOT;
                            state_next = (flags.func == imhq_pkg::FN_UPDATE) ? S_UPD_R
                                                                             : S_READ_R;
                        end
                    end
                    imhq_pkg::FN_FIND: begin
                        cmd.act    = imhq_pkg::A_SCAN_START;
                        state_next = S_SCAN_CHK;
                    end
                    default: begin
                        cmd.act = imhq_pkg::A_CLEAR;
                    end
                endcase
            end
            S_EXT_R: begin
                cmd.act    = imhq_pkg::A_ROOT_RES;
                cmd.rd     = imhq_pkg::RD_LAST;
                state_next = S_EXT_L;
            end
            S_EXT_L: begin
                cmd.act    = imhq_pkg::A_EXT_LAST;
                state_next = S_DN_CHK;
            end
            S_POP_R: begin
                cmd.act    = imhq_pkg::A_ROOT_RES;
                state_next = S_POP_S;
            end
            S_POP_S: begin
                cmd.act    = imhq_pkg::A_POP_START;
                state_next = S_DN_CHK;
            end
            S_UPD_R: begin
                cmd.act    = imhq_pkg::A_UPD_START;
                state_next = S_DN_CHK;
            end
            S_PEEK_R: begin
                cmd.act    = imhq_pkg::A_PEEK_RES;
                state_next = S_DONE;
            end
            S_READ_R: begin
                cmd.act    = imhq_pkg::A_READ_RES;
                state_next = S_DONE;
            end
            // sift up: one parent read and compare per level
            S_UP_CHK: begin
                if (flags.pos_gt1) begin
                    cmd.rd     = imhq_pkg::RD_PARENT;
                    state_next = S_UP_CMP;
                end else begin
                    cmd.act    = imhq_pkg::A_UP_PLACE;
                    state_next = S_DONE;
                end
            end
            S_UP_CMP: begin
                if (flags.up_less) begin
                    cmd.act    = imhq_pkg::A_UP_MOVE;
                    state_next = S_UP_CHK;
                end else begin
                    cmd.act    = imhq_pkg::A_UP_PLACE;
                    state_next = S_DONE;
                end
            end
            // sift down: read the left child and the right one if present, pick the smaller, then move or place
            S_DN_CHK: begin
                if (flags.chd_gt_occ) begin
                    cmd.act    = imhq_pkg::A_DN_PLACE;
                    state_next = S_DONE;
                end else begin
                    cmd.rd     = imhq_pkg::RD_CHD;
                    state_next = S_DN_C1;
                end
            end
            S_DN_C1: begin
                cmd.act = imhq_pkg::A_DN_C1;
                if (flags.chd_lt_occ) begin
                    cmd.rd     = imhq_pkg::RD_CHD1;
                    state_next = S_DN_C2;
                end else begin
                    state_next = S_DN_DEC;
                end
            end
            S_DN_C2: begin
                cmd.act    = imhq_pkg::A_DN_C2;
                state_next = S_DN_DEC;
            end
            S_DN_DEC: begin
                if (flags.cand_less) begin
                    cmd.act    = imhq_pkg::A_DN_MOVE;
                    state_next = S_DN_CHK;
                end else begin
                    cmd.act    = imhq_pkg::A_DN_PLACE;
                    state_next = S_DONE;
                end
            end
            // id search over occupied slots, lowest first
            S_SCAN_CHK: begin
                if (flags.scan_end) begin
                    cmd.act    = imhq_pkg::A_FAIL;
                    cmd.st     = imhq_pkg::ST_NOTFOUND;
                    state_next = S_DONE;
                end else begin
                    cmd.rd     = imhq_pkg::RD_POS;
                    state_next = S_SCAN_CMP;
                end
            end
            S_SCAN_CMP: begin
                cmd.act    = imhq_pkg::A_SCAN_STEP;
                state_next = flags.id_match ? S_DONE : S_SCAN_CHK;
            end
            S_DONE: begin
                if (out_free) begin
                    cmd.out_load = 1'b1;
                    mvalid_next  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // state and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            mvalid_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            mvalid_reg <= mvalid_next;
        end
    end

endmodule

[hw/rtl/indexed_min_heap_queue.sv]
// Indexed binary min-heap of 256 decoder hypotheses keyed on signed Q16.16 log probability.
// One operation at a time; each is accepted, dispatched, then posts its result word. Insert
// sifts up with one parent read and compare per level; extract, pop-and-insert and update
// sift down with up to two child reads per level through the single read port of the
// entry memory, then a decision; find scans the occupied slots lowest first, stopping at
// an id match; peek and read add a result read state, clear none. A new input word is taken
// while a result word still waits at the output register. No clearing pass after reset.
module indexed_min_heap_queue (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_func,
    input  logic [23:0] s_graph_state,
    input  logic [7:0]  s_model_state,
    input  logic signed [31:0] s_log_prob,
    input  logic signed [31:0] s_model_log_prob,
    input  logic signed [31:0] s_lm_log_prob,
    input  logic [15:0] s_transition_pos,
    input  logic [15:0] s_hyp_ref,
    input  logic [8:0]  s_slot,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [8:0]  m_out_slot,
    output logic [23:0] m_out_graph_state,
    output logic [7:0]  m_out_model_state,
    output logic signed [31:0] m_out_log_prob,
    output logic signed [31:0] m_out_model_log_prob,
    output logic signed [31:0] m_out_lm_log_prob,
    output logic [15:0] m_out_transition_pos,
    output logic [15:0] m_out_hyp_ref,
    output logic [8:0]  m_entry_count
);

`include "indexed_min_heap_queue_macros.svh"

    imhq_pkg::cmd_t   cmd;
    imhq_pkg::flags_t flags;
    imhq_pkg::entry_t in_ent;
    imhq_pkg::entry_t out_ent;

    // pack the input word into an entry
    always_comb begin
        in_ent.id  = {s_graph_state, s_model_state};
        in_ent.key = s_log_prob;
        in_ent.mp  = s_model_log_prob;
        in_ent.lp  = s_lm_log_prob;
        in_ent.pay = {s_transition_pos, s_hyp_ref};
    end

    imhq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .flags   (flags),
        .cmd     (cmd)
    );

    imhq_datapath u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .flags      (flags),
        .in_func    (s_func),
        .in_ent     (in_ent),
        .in_slot    (s_slot),
        .out_status (m_status),
        .out_slot   (m_out_slot),
        .out_ent    (out_ent),
        .out_count  (m_entry_count)
    );

    // unpack the result entry
    assign m_out_graph_state    = out_ent.id[31:8];
    assign m_out_model_state    = out_ent.id[7:0];
    assign m_out_log_prob       = out_ent.key;
    assign m_out_model_log_prob = out_ent.mp;
    assign m_out_lm_log_prob    = out_ent.lp;
    assign m_out_transition_pos = out_ent.pay[31:16];
    assign m_out_hyp_ref        = out_ent.pay[15:0];

    // checks
    `IMHQ_ASSERT_IMPL(a_count_cap, m_valid, m_entry_count <= 9'(imhq_pkg::HEAP_CAPACITY))
    `IMHQ_ASSERT_IMPL(a_full_count, m_valid && m_status == imhq_pkg::ST_FULL, m_entry_count == 9'(imhq_pkg::HEAP_CAPACITY))
    `IMHQ_ASSERT_IMPL(a_empty_count, m_valid && m_status == imhq_pkg::ST_EMPTY, m_entry_count == 9'd0)
    `IMHQ_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready)

endmodule
